@@ rtl/owner_tagged_block_allocator_defines.svh @@
// Assertion macros for the block allocator.
`ifndef OWNER_TAGGED_BLOCK_ALLOCATOR_DEFINES_SVH
`define OWNER_TAGGED_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define OTBA_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("block allocator check failed");

`define OTBA_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("block allocator check failed");

`else

`define OTBA_ASSERT_IMP(lbl, clk, rst_n, pre, post)

`define OTBA_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

@@ rtl/otba_pkg.sv @@
package otba_pkg;

  localparam int BLOCKS    = 64;
  localparam int RESERVED  = 5;
  localparam int IDX_W     = $clog2(BLOCKS);
  localparam int CNT_W     = $clog2(BLOCKS + 1);
  localparam int STRIDE    = 7;
  localparam int START_RST = (RESERVED * STRIDE) % BLOCKS;
  localparam int RAM_W     = 16;

  localparam logic [7:0] KCOLOR_RST  = 8'h01;
  localparam logic [7:0] COLOR_FORCE = 8'hFF;
  localparam logic [7:0] BAD_FIELD   = 8'hFF;
  localparam logic [3:0] BAD_MARKS   = 4'hF;
  localparam logic [3:0] MARK_ALLOC  = 4'h1;
  localparam logic [3:0] MARK_LOCK   = 4'h8;

  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE_ONE = 2'd1,
    KIND_FREE_ALL = 2'd2,
    KIND_INSPECT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_LOCKED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ACT_FETCH    = 3'd0,
    ACT_ALLOC    = 3'd1,
    ACT_FREE1    = 3'd2,
    ACT_FA_PRIME = 3'd3,
    ACT_FA_CHK   = 3'd4,
    ACT_INSP_RD  = 3'd5,
    ACT_INSP     = 3'd6,
    ACT_EMIT     = 3'd7
  } act_e;

  typedef struct packed {
    logic  in_valid;
    kind_e kind;
    logic  scan_end;
    logic  last;
    logic  out_free;
  } cond_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] block_index;
    logic [7:0] owner_id;
    logic [7:0] color_tag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_block;
    logic [7:0] result_color;
    logic [7:0] result_owner;
    logic [3:0] result_marks;
    logic [6:0] used_count;
    logic [6:0] avail_count;
    logic [6:0] locked_count;
  } rsp_t;

  function automatic logic blk_locked(input logic [7:0] idx);
    return 9'(idx) < 9'(RESERVED);
  endfunction

endpackage

@@ rtl/otba_if.sv @@
interface otba_req_if import otba_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface otba_rsp_if import otba_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/otba_ram.sv @@
module otba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/otba_seq.sv @@
module otba_seq import otba_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output act_e  act_o
);

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_VALID = 3'd1,
    COND_SCAN_END = 3'd2,
    COND_LAST     = 3'd3,
    COND_OUT_FREE = 3'd4
  } cond_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_FETCH    = 3'd0;
  localparam upc_t UPC_ALLOC    = 3'd1;
  localparam upc_t UPC_FREE1    = 3'd2;
  localparam upc_t UPC_FA_PRIME = 3'd3;
  localparam upc_t UPC_FA_CHK   = 3'd4;
  localparam upc_t UPC_INSP_RD  = 3'd5;
  localparam upc_t UPC_INSP     = 3'd6;
  localparam upc_t UPC_EMIT     = 3'd7;
  localparam int   UPC_NUM      = 8;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    logic  dispatch;
    upc_t  next_t;
    upc_t  next_f;
  } ucode_t;

  localparam ucode_t UCODE [UPC_NUM] = '{
    '{ACT_FETCH,    COND_IN_VALID, 1'b1, UPC_FETCH,  UPC_FETCH},
    '{ACT_ALLOC,    COND_SCAN_END, 1'b0, UPC_EMIT,   UPC_ALLOC},
    '{ACT_FREE1,    COND_ALWAYS,   1'b0, UPC_EMIT,   UPC_EMIT},
    '{ACT_FA_PRIME, COND_ALWAYS,   1'b0, UPC_FA_CHK, UPC_FA_CHK},
    '{ACT_FA_CHK,   COND_LAST,     1'b0, UPC_EMIT,   UPC_FA_CHK},
    '{ACT_INSP_RD,  COND_ALWAYS,   1'b0, UPC_INSP,   UPC_INSP},
    '{ACT_INSP,     COND_ALWAYS,   1'b0, UPC_EMIT,   UPC_EMIT},
    '{ACT_EMIT,     COND_OUT_FREE, 1'b0, UPC_FETCH,  UPC_EMIT}
  };

  function automatic upc_t entry(input kind_e kind);
    upc_t pc;
    case (kind)
      KIND_ALLOC:    pc = UPC_ALLOC;
      KIND_FREE_ONE: pc = UPC_FREE1;
      KIND_FREE_ALL: pc = UPC_FA_PRIME;
      KIND_INSPECT:  pc = UPC_INSP_RD;
      default:       pc = UPC_FETCH;
    endcase
    return pc;
  endfunction

  upc_t   upc_q, upc_d;
  ucode_t uc;
  logic   taken;

  assign uc    = UCODE[upc_q];
  assign act_o = uc.act;

  always_comb begin
    case (uc.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_IN_VALID: taken = cond_i.in_valid;
      COND_SCAN_END: taken = cond_i.scan_end;
      COND_LAST:     taken = cond_i.last;
      COND_OUT_FREE: taken = cond_i.out_free;
      default:       taken = 1'b1;
    endcase
    if (!taken) begin
      upc_d = uc.next_f;
    end else if (uc.dispatch) begin
      upc_d = entry(cond_i.kind);
    end else begin
      upc_d = uc.next_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ rtl/otba_dp.sv @@
module otba_dp import otba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  act_e              act_i,
  output cond_t             cond_o,
  otba_req_if.sink          req_i,
  otba_rsp_if.source        rsp_o
);

  logic [7:0]        kcolor_q, kcolor_d;
  logic [BLOCKS-1:0] alloc_q, alloc_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  start_q, start_d;
  logic              out_valid_q, out_valid_d;

  req_t              item_q, item_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  status_e           st_q, st_d;
  logic [7:0]        rblock_q, rblock_d;
  logic [7:0]        rcolor_q, rcolor_d;
  logic [7:0]        rowner_q, rowner_d;
  logic [3:0]        rmarks_q, rmarks_d;
  rsp_t              out_q, out_d;

  logic [IDX_W-1:0]  ptr_next;
  logic [IDX_W-1:0]  idx_w;
  logic              idx_ok;
  logic              free_at_ptr;
  logic              scan_last;
  logic              out_free;
  logic [IDX_W:0]    start_sum;
  logic [IDX_W:0]    start_dif;
  logic [IDX_W-1:0]  start_up;
  logic [IDX_W-1:0]  start_dn;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [7:0]        new_color;
  logic              insp_lk;
  logic              insp_al;

  assign ptr_next    = (ptr_q == IDX_W'(BLOCKS - 1)) ? '0 : ptr_q + 1'b1;
  assign idx_w       = item_q.block_index[IDX_W-1:0];
  assign idx_ok      = 9'(item_q.block_index) < 9'(BLOCKS);
  assign free_at_ptr = !alloc_q[ptr_q] && !blk_locked(8'(ptr_q));
  assign scan_last   = ptr_q == IDX_W'(BLOCKS - 1);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign start_sum = {1'b0, start_q} + (IDX_W+1)'(STRIDE);
  assign start_up  = (start_sum >= (IDX_W+1)'(BLOCKS)) ?
                     IDX_W'(start_sum - (IDX_W+1)'(BLOCKS)) : IDX_W'(start_sum);
  assign start_dif = (start_q >= IDX_W'(STRIDE)) ?
                     ({1'b0, start_q} - (IDX_W+1)'(STRIDE)) :
                     ({1'b0, start_q} + (IDX_W+1)'(BLOCKS - STRIDE));
  assign start_dn  = IDX_W'(start_dif);

  assign new_color = (item_q.color_tag != 8'h00) ? item_q.color_tag : COLOR_FORCE;
  assign ram_we    = (act_i == ACT_ALLOC) && free_at_ptr;
  assign ram_wdata = {new_color, item_q.owner_id};

  always_comb begin
    case (act_i)
      ACT_FA_CHK:  ram_raddr = ptr_next;
      ACT_INSP_RD: ram_raddr = idx_w;
      default:     ram_raddr = ptr_q;
    endcase
  end

  otba_ram #(
    .WIDTH (RAM_W),
    .DEPTH (BLOCKS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign insp_lk = blk_locked(item_q.block_index);
  assign insp_al = alloc_q[idx_w];

  always_comb begin
    kcolor_d    = cfg_we_i ? cfg_data_i : kcolor_q;
    alloc_d     = alloc_q;
    used_d      = used_q;
    start_d     = start_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    item_d      = item_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    rblock_d    = rblock_q;
    rcolor_d    = rcolor_q;
    rowner_d    = rowner_q;
    rmarks_d    = rmarks_q;
    out_d       = out_q;

    case (act_i)
      ACT_FETCH: begin
        if (req_i.valid) begin
          item_d   = req_i.payload;
          ptr_d    = (kind_e'(req_i.payload.kind) == KIND_ALLOC) ? start_q : '0;
          cnt_d    = '0;
          st_d     = ST_OK;
          rblock_d = 8'h00;
          rcolor_d = 8'h00;
          rowner_d = 8'h00;
          rmarks_d = 4'h0;
        end
      end
      ACT_ALLOC: begin
        if (free_at_ptr) begin
          alloc_d[ptr_q] = 1'b1;
          used_d         = used_q + 1'b1;
          start_d        = start_up;
          rblock_d       = 8'(ptr_q);
        end else if (cnt_q == IDX_W'(BLOCKS - 1)) begin
          st_d = ST_NOFREE;
        end else begin
          ptr_d = ptr_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ACT_FREE1: begin
        rblock_d = item_q.block_index;
        if (!idx_ok) begin
          st_d = ST_RANGE;
        end else if (insp_lk) begin
          st_d = ST_LOCKED;
        end else if (insp_al) begin
          alloc_d[idx_w] = 1'b0;
          used_d         = used_q - 1'b1;
          start_d        = start_dn;
        end
      end
      ACT_FA_PRIME: begin
      end
      ACT_FA_CHK: begin
        if (alloc_q[ptr_q] && !blk_locked(8'(ptr_q)) &&
            ram_rdata[7:0] == item_q.owner_id) begin
          alloc_d[ptr_q] = 1'b0;
          used_d         = used_q - 1'b1;
          start_d        = start_dn;
        end
        ptr_d = ptr_next;
      end
      ACT_INSP_RD: begin
      end
      ACT_INSP: begin
        rblock_d = item_q.block_index;
        if (!idx_ok) begin
          st_d     = ST_RANGE;
          rcolor_d = BAD_FIELD;
          rowner_d = BAD_FIELD;
          rmarks_d = BAD_MARKS;
        end else begin
          rcolor_d = insp_lk ? kcolor_q : (insp_al ? ram_rdata[15:8] : 8'h00);
          rowner_d = insp_al ? ram_rdata[7:0] : 8'h00;
          rmarks_d = (insp_al ? MARK_ALLOC : 4'h0) | (insp_lk ? MARK_LOCK : 4'h0);
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_d.status       = st_q;
          out_d.result_block = rblock_q;
          out_d.result_color = rcolor_q;
          out_d.result_owner = rowner_q;
          out_d.result_marks = rmarks_q;
          out_d.used_count   = 7'(used_q);
          out_d.avail_count  = 7'(CNT_W'(BLOCKS) - used_q);
          out_d.locked_count = 7'(RESERVED);
          out_valid_d        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcolor_q    <= KCOLOR_RST;
      alloc_q     <= '0;
      used_q      <= CNT_W'(RESERVED);
      start_q     <= IDX_W'(START_RST);
      out_valid_q <= 1'b0;
    end else begin
      kcolor_q    <= kcolor_d;
      alloc_q     <= alloc_d;
      used_q      <= used_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    ptr_q    <= ptr_d;
    cnt_q    <= cnt_d;
    st_q     <= st_d;
    rblock_q <= rblock_d;
    rcolor_q <= rcolor_d;
    rowner_q <= rowner_d;
    rmarks_q <= rmarks_d;
    out_q    <= out_d;
  end

  assign req_i.ready   = act_i == ACT_FETCH;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  assign cond_o.in_valid = req_i.valid;
  assign cond_o.kind     = kind_e'(req_i.payload.kind);
  assign cond_o.scan_end = free_at_ptr || (cnt_q == IDX_W'(BLOCKS - 1));
  assign cond_o.last     = scan_last;
  assign cond_o.out_free = out_free;

endmodule

@@ rtl/owner_tagged_block_allocator.sv @@
// Fixed block allocator with owner and color tags. One request transaction is taken at a
// time from the request channel; each gives exactly one response transaction. A small
// microcode program steps a datapath that holds one allocation bit per block in flops and
// the color/owner tags in a single-port-read RAM. A request runs a fetch step, its kind's
// steps, then a response step. Allocate scans one block per cycle from the start point
// until a free block is found, from 1 to BLOCKS blocks; free one block runs a free step;
// free all blocks of an owner runs a priming step, then one tag RAM read per block; inspect
// runs a read step and an inspect step. The next request is taken while a response still
// waits in the output register. No clearing pass after reset; reserved blocks stay locked.
`include "owner_tagged_block_allocator_defines.svh"

module owner_tagged_block_allocator import otba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  otba_req_if.sink   req_i,
  otba_rsp_if.source rsp_o
);

  act_e  act;
  cond_t cond;

  otba_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .act_o  (act)
  );

  otba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .act_i      (act),
    .cond_o     (cond),
    .req_i      (req_i),
    .rsp_o      (rsp_o)
  );

  `OTBA_ASSERT_IMP(a_counts_sum, clk_i, rst_ni, rsp_o.valid,
    (rsp_o.payload.used_count + rsp_o.payload.avail_count) == 7'(BLOCKS))

  `OTBA_ASSERT_NXT(a_leave_fetch, clk_i, rst_ni, req_i.valid && req_i.ready,
    act != ACT_FETCH)

  `OTBA_ASSERT_IMP(a_locked_reserved, clk_i, rst_ni,
    rsp_o.valid && rsp_o.payload.status == ST_LOCKED,
    9'(rsp_o.payload.result_block) < 9'(RESERVED))

endmodule
